FILE: src/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants of the insertion sort engine.
// ----------------------------------------------------------------------------
package isort_pkg;

   // width of one sorted element
   localparam int DATA_W = 32;

   // command broadcast to every cell of the row
   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_INS  = 2'd1,
      OP_UP   = 2'd2,
      OP_DOWN = 2'd3
   } isort_op_type;

   // what a cell hands to its upper neighbor; its value also goes to the lower one
   typedef struct packed {
      logic                     lt;
      logic signed [DATA_W-1:0] value;
   } isort_link_type;

   // control states of the top level
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } isort_state_type;

endpackage

FILE: src/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorting row: holds an element, compares it with the
// arriving word and takes the new word or its own, its lower or its upper neighbor's value.
// ----------------------------------------------------------------------------
module isort_cell
   import isort_pkg::*;
(
   input  logic                     clock,
   input  isort_op_type             op,
   input  logic signed [DATA_W-1:0] ins_value,
   input  logic                     occupied,
   input  isort_link_type           below,
   input  logic signed [DATA_W-1:0] above_value,
   output isort_link_type           link
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     lt;

   // new word goes at or below this slot
   assign lt = !occupied || (ins_value < value_ff);

   always_comb begin
      value_in = value_ff;
      unique case (op)
         OP_INS: begin
            if (lt) begin
               value_in = below.lt ? below.value : ins_value;
            end
         end
         OP_UP:   value_in = below.value;
         OP_DOWN: value_in = above_value;
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.lt    = lt;
   assign link.value = value_ff;

endmodule

FILE: src/isort_chain.sv
// ----------------------------------------------------------------------------
// isort_chain
// Row of sorting cells kept in ascending order from cell 0 upward, with the
// bottom and top cells exposed for draining.
// ----------------------------------------------------------------------------
module isort_chain
   import isort_pkg::*;
#(
   parameter int MAX_LEN = 64,
   parameter int CW      = $clog2(MAX_LEN + 1)
)
(
   input  logic                     clock,
   input  isort_op_type             op,
   input  logic signed [DATA_W-1:0] ins_value,
   input  logic [CW-1:0]            count,
   output logic signed [DATA_W-1:0] bottom_value,
   output logic signed [DATA_W-1:0] top_value
);

   isort_link_type links [MAX_LEN];

   genvar i;
   generate
      for (i = 0; i < MAX_LEN; i++) begin : g_cell
         isort_link_type           below;
         logic signed [DATA_W-1:0] above_value;
         logic                     occupied;

         assign occupied = CW'(i) < count;

         // neighbor hookup, open ends tied off
         if (i == 0) begin : g_bottom
            assign below = '{lt: 1'b0, value: '0};
         end else begin : g_mid_lo
            assign below = links[i-1];
         end
         if (i == MAX_LEN - 1) begin : g_top
            assign above_value = '0;
         end else begin : g_mid_hi
            assign above_value = links[i+1].value;
         end

         isort_cell u_cell (
            .clock       (clock),
            .op          (op),
            .ins_value   (ins_value),
            .occupied    (occupied),
            .below       (below),
            .above_value (above_value),
            .link        (links[i])
         );
      end
   endgenerate

   assign bottom_value = links[0].value;
   assign top_value    = links[MAX_LEN-1].value;

endmodule

FILE: src/insertion_sort_engine_core.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine_core
// Batch insertion sorter of signed 32-bit words built on a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one element per word, tlast marks the batch end.
//    Each word is inserted into the cell row in the cycle it is accepted,
//    so a batch streams in at one word per cycle.
//  - after the last word the batch is emitted on rsp, one word per cycle
//    while rsp_tready is high, tlast on the final word and tuser carrying
//    the overflow flag on every word of a run that lost elements.
//  - ascending order: the first result is registered in the drain phase after the
//    last input; descending order: the row first shifts up by MAX_LEN - n slots
//    so the largest element sits in the top cell, n = number of stored elements.
//  - req_tready is low from the last input until the final result is in
//    the output register.
//  - words beyond MAX_LEN are dropped; a dropped last word still ends it.
//  - csr_wdata selects descending order (1), written on csr_we, sampled at the batch end.
//  - reset clears the count, flags, order bit and output valid; no
//    clearing pass of the cells is needed. A stalled receiver holds the
//    output word and freezes the row while a run is emitted.
// ----------------------------------------------------------------------------
module insertion_sort_engine_core
   import isort_pkg::*;
#(
   parameter int MAX_LEN = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: value[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: sorted_value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: overflow[0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

   isort_state_type state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic            desc_ff;
   logic            drain_desc_ff, drain_desc_in;
   logic [CW-1:0]   run_len_ff, run_len_in;
   logic [CW-1:0]   pad_ff, pad_in;
   logic [IW-1:0]   emit_ff, emit_in;

   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_data_ff, out_data_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_ovf_ff, out_ovf_in;

   isort_op_type             op;
   logic signed [DATA_W-1:0] bottom_value, top_value;
   logic                     req_fire, load, final_word;
   logic [CW-1:0]            count_next;

   // cell row
   isort_chain #(
      .MAX_LEN (MAX_LEN),
      .CW      (CW)
   ) u_chain (
      .clock        (clock),
      .op           (op),
      .ins_value    (req_tdata),
      .count        (count_ff),
      .bottom_value (bottom_value),
      .top_value    (top_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load       = (state_ff == ST_DRAIN) && !(drain_desc_ff && pad_ff != '0)
                       && (!out_valid_ff || rsp_tready);
   assign final_word = (CW'(emit_ff) == run_len_ff - CW'(1));
   assign count_next = (count_ff == FULL) ? count_ff : count_ff + CW'(1);

   // control and row command
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      drain_desc_in = drain_desc_ff;
      run_len_in    = run_len_ff;
      pad_in        = pad_ff;
      emit_in       = emit_ff;
      op            = OP_HOLD;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      out_ovf_in    = out_ovf_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff == FULL) begin
                  dropped_in = 1'b1;
               end else begin
                  op = OP_INS;
               end
               count_in = count_next;
               if (req_tlast) begin
                  state_in      = ST_DRAIN;
                  drain_desc_in = desc_ff;
                  run_len_in    = count_next;
                  pad_in        = FULL - count_next;
                  emit_in       = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_desc_ff && pad_ff != '0) begin
               // align the largest element with the top cell
               op     = OP_UP;
               pad_in = pad_ff - CW'(1);
            end else if (load) begin
               op           = drain_desc_ff ? OP_UP : OP_DOWN;
               out_valid_in = 1'b1;
               out_data_in  = drain_desc_ff ? top_value : bottom_value;
               out_last_in  = final_word;
               out_ovf_in   = dropped_ff;
               emit_in      = emit_ff + IW'(1);
               if (final_word) begin
                  state_in   = ST_IDLE;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         desc_ff       <= 1'b0;
         drain_desc_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         drain_desc_ff <= drain_desc_in;
         out_valid_ff  <= out_valid_in;
         if (csr_we) begin
            desc_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_len_ff  <= run_len_in;
      pad_ff      <= pad_in;
      emit_ff     <= emit_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

FILE: src/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks of the insertion sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // no input taken in the middle of a run
   a_no_req_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input accepted while a run is emitted");

   // a run starts only from the drain phase
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while accepting input");

   // overflow flag is constant across one run
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
         |-> rsp_tuser == $past(rsp_tuser))
      else $error("overflow flag changed within a run");

endmodule

bind insertion_sort_engine_core isort_checker u_isort_checker (.*);
